[rtl/tfn_pkg.sv]
package tfn_pkg;

    // defaults for the top-level parameters
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // edge differences are kept to this many bits before the sign bit
    localparam int DIFF_KEEP_BITS = 23;
    // significant bits of the largest cross component after block scaling
    localparam int NORM_BITS      = 30;
    // sum of three squares of NORM_BITS values
    localparam int SQ_SUM_W       = 2 * NORM_BITS + 2;
    // width of the integer square root of that sum
    localparam int ROOT_W         = NORM_BITS + 1;

    // width of one signed edge difference
    function automatic int tfn_diff_w(input int cw);
        return (cw > DIFF_KEEP_BITS) ? DIFF_KEEP_BITS + 1 : cw + 1;
    endfunction

    // arithmetic right shift applied to each edge difference
    function automatic int tfn_diff_shift(input int cw);
        return (cw > DIFF_KEEP_BITS) ? cw - DIFF_KEEP_BITS : 0;
    endfunction

    // width of one signed cross component (also of its magnitude)
    function automatic int tfn_cross_w(input int cw);
        return 2 * tfn_diff_w(cw) + 1;
    endfunction

endpackage

[rtl/triangle_face_normal_core.sv]
// Unit face normal of a triangle, one triangle per beat.
//
// Input beat (s_ channel): the corners a, b, c as nine signed Q8.8 values
// packed in s_tdata. Output beat (m_ channel): the unit normal of
// (b - c) x (a - b) as three signed Q1.14 values in m_tdata, and in m_tuser
// a flag that is set when the cross product is zero; the normal is then 0.
//
// Throughput: one triangle per cycle unless the output stalls, fully pipelined.
// Each triangle passes in order through the edge and cross-product math,
// the block scaling and sum of squares, the bit-per-stage square root and
// the three parallel restoring dividers, and last the output register.
//
// The output register is backed by a skid register. When m_tready is low a
// result waits in the output register, one more is caught in the skid, and
// only then does the pipeline freeze and s_tready drop (s_tready is
// registered). Nothing is lost or repeated under stalls.
// Reset (aresetn low, synchronous) empties the pipeline and both registers.
module triangle_face_normal_core
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
    localparam int IN_W  = (((9 * COORD_WIDTH) + 7) / 8) * 8,
    localparam int OW    = NORMAL_FRAC_BITS + 2,
    localparam int OUT_W = (((3 * OW) + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz (lowest first), zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // nx, ny, nz (lowest first), zero pad
    output logic [OUT_W-1:0] m_tdata,
    // degenerate
    output logic             m_tuser
);

    localparam int MW  = tfn_cross_w(COORD_WIDTH);
    localparam int PLW = 3 * NORM_BITS + 4;

    logic en;

    logic                   cr_valid;
    logic [3*MW-1:0]        cr_mag;
    logic [2:0]             cr_neg;

    logic                   nm_valid;
    logic [SQ_SUM_W-1:0]    nm_sum;
    logic [3*NORM_BITS-1:0] nm_smag;
    logic [2:0]             nm_neg;
    logic                   nm_deg;

    logic                   sq_valid;
    logic [ROOT_W-1:0]      sq_root;
    logic [PLW-1:0]         sq_pl;

    logic                   dv_valid;
    logic [3*OW-1:0]        dv_norm;
    logic                   dv_deg;

    logic                   out_v_reg;
    logic [3*OW-1:0]        out_norm_reg;
    logic                   out_deg_reg;
    logic                   skid_v_reg;
    logic [3*OW-1:0]        skid_norm_reg;
    logic                   skid_deg_reg;

    // pipeline moves whenever the skid register is free
    assign en       = ~skid_v_reg;
    assign s_tready = en;

    tfn_cross #(
        .CW (COORD_WIDTH)
    ) u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata[9*COORD_WIDTH-1:0]),
        .out_valid (cr_valid),
        .out_mag   (cr_mag),
        .out_neg   (cr_neg)
    );

    tfn_norm #(
        .MW (MW)
    ) u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cr_valid),
        .in_mag    (cr_mag),
        .in_neg    (cr_neg),
        .out_valid (nm_valid),
        .out_sum   (nm_sum),
        .out_smag  (nm_smag),
        .out_neg   (nm_neg),
        .out_deg   (nm_deg)
    );

    tfn_sqrt #(
        .PLW (PLW)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (nm_valid),
        .in_sum    (nm_sum),
        .in_pl     ({nm_deg, nm_neg, nm_smag}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_pl    (sq_pl)
    );

    tfn_div #(
        .F (NORMAL_FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_len    (sq_root),
        .in_smag   (sq_pl[3*NORM_BITS-1:0]),
        .in_neg    (sq_pl[3*NORM_BITS +: 3]),
        .in_deg    (sq_pl[PLW-1]),
        .out_valid (dv_valid),
        .out_norm  (dv_norm),
        .out_deg   (dv_deg)
    );

    // output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || m_tready) begin
            out_v_reg  <= skid_v_reg | dv_valid;
            skid_v_reg <= 1'b0;
        end else if (en && dv_valid) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_tready) begin
            out_norm_reg <= skid_v_reg ? skid_norm_reg : dv_norm;
            out_deg_reg  <= skid_v_reg ? skid_deg_reg : dv_deg;
        end else if (en && dv_valid) begin
            skid_norm_reg <= dv_norm;
            skid_deg_reg  <= dv_deg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OUT_W'(out_norm_reg);
    assign m_tuser  = out_deg_reg;

endmodule

[rtl/tfn_cross.sv]
module tfn_cross
    import tfn_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    localparam int MW = tfn_cross_w(CW)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [9*CW-1:0]   in_data,
    output logic              out_valid,
    output logic [3*MW-1:0]   out_mag,
    output logic [2:0]        out_neg
);

    localparam int DW = tfn_diff_w(CW);
    localparam int ES = tfn_diff_shift(CW);
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];
    logic signed [DW-1:0] e1_next [3];
    logic signed [DW-1:0] e2_next [3];
    logic                 v1_reg;

    logic signed [PW-1:0] prod_reg [6];
    logic signed [PW-1:0] prod_next [6];
    logic                 v2_reg;

    logic [MW-1:0]        mag_reg [3];
    logic [MW-1:0]        mag_next [3];
    logic [2:0]           neg_reg;
    logic [2:0]           neg_next;
    logic                 v3_reg;

    // edge differences e1 = a - b, e2 = b - c, floor-shifted to fit
    always_comb begin
        logic signed [CW:0] pa;
        logic signed [CW:0] pb;
        logic signed [CW:0] pc;
        logic signed [CW:0] d1;
        logic signed [CW:0] d2;
        for (int k = 0; k < 3; k++) begin
            pa = (CW+1)'(signed'(in_data[k*CW +: CW]));
            pb = (CW+1)'(signed'(in_data[(3+k)*CW +: CW]));
            pc = (CW+1)'(signed'(in_data[(6+k)*CW +: CW]));
            d1 = (pa - pb) >>> ES;
            d2 = (pb - pc) >>> ES;
            e1_next[k] = d1[DW-1:0];
            e2_next[k] = d2[DW-1:0];
        end
    end

    // six partial products of e2 x e1
    always_comb begin
        prod_next[0] = PW'(e2_reg[1]) * PW'(e1_reg[2]);
        prod_next[1] = PW'(e2_reg[2]) * PW'(e1_reg[1]);
        prod_next[2] = PW'(e2_reg[2]) * PW'(e1_reg[0]);
        prod_next[3] = PW'(e2_reg[0]) * PW'(e1_reg[2]);
        prod_next[4] = PW'(e2_reg[0]) * PW'(e1_reg[1]);
        prod_next[5] = PW'(e2_reg[1]) * PW'(e1_reg[0]);
    end

    // cross components, split into magnitude and sign
    always_comb begin
        logic signed [MW-1:0] cr;
        for (int k = 0; k < 3; k++) begin
            cr = MW'(prod_reg[2*k]) - MW'(prod_reg[2*k + 1]);
            neg_next[k] = cr[MW-1];
            mag_next[k] = cr[MW-1] ? MW'(-cr) : MW'(cr);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            prod_reg <= prod_next;
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_neg   = neg_reg;
    assign out_mag   = {mag_reg[2], mag_reg[1], mag_reg[0]};

endmodule

[rtl/tfn_norm.sv]
module tfn_norm
    import tfn_pkg::*;
#(
    parameter int MW = tfn_cross_w(COORD_WIDTH_DEF)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [3*MW-1:0]        in_mag,
    input  logic [2:0]             in_neg,
    output logic                   out_valid,
    output logic [SQ_SUM_W-1:0]    out_sum,
    output logic [3*NORM_BITS-1:0] out_smag,
    output logic [2:0]             out_neg,
    output logic                   out_deg
);

    localparam int BLW = $clog2(MW + 1);
    localparam int SW  = MW + NORM_BITS;
    localparam int QW2 = 2 * NORM_BITS;

    // stage A: magnitudes and their OR (same bit length as the largest)
    logic [MW-1:0]  a_mag_reg [3];
    logic [2:0]     a_neg_reg;
    logic [MW-1:0]  a_or_reg;
    logic           a_v_reg;

    // stage B: bit length of the largest magnitude
    logic [MW-1:0]  b_mag_reg [3];
    logic [2:0]     b_neg_reg;
    logic [BLW-1:0] b_bl_reg;
    logic [BLW-1:0] b_bl_next;
    logic           b_deg_reg;
    logic           b_v_reg;

    // stage C: block-scaled magnitudes
    logic [NORM_BITS-1:0] c_smag_reg [3];
    logic [NORM_BITS-1:0] c_smag_next [3];
    logic [2:0]           c_neg_reg;
    logic                 c_deg_reg;
    logic                 c_v_reg;

    // stage D: squares
    logic [QW2-1:0]       d_sq_reg [3];
    logic [NORM_BITS-1:0] d_smag_reg [3];
    logic [2:0]           d_neg_reg;
    logic                 d_deg_reg;
    logic                 d_v_reg;

    // stage E: sum of squares
    logic [SQ_SUM_W-1:0]  e_sum_reg;
    logic [NORM_BITS-1:0] e_smag_reg [3];
    logic [2:0]           e_neg_reg;
    logic                 e_deg_reg;
    logic                 e_v_reg;

    // highest set bit of the OR, plus one
    always_comb begin
        b_bl_next = '0;
        for (int i = 0; i < MW; i++) begin
            if (a_or_reg[i]) begin
                b_bl_next = BLW'(i + 1);
            end
        end
    end

    // (mag << NORM_BITS) >> bl leaves the top NORM_BITS significant bits
    always_comb begin
        logic [SW-1:0] wide;
        for (int k = 0; k < 3; k++) begin
            wide = {b_mag_reg[k], {NORM_BITS{1'b0}}} >> b_bl_reg;
            c_smag_next[k] = wide[NORM_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                a_mag_reg[k]  <= in_mag[k*MW +: MW];
                b_mag_reg[k]  <= a_mag_reg[k];
                c_smag_reg[k] <= c_smag_next[k];
                d_sq_reg[k]   <= QW2'(c_smag_reg[k]) * QW2'(c_smag_reg[k]);
                d_smag_reg[k] <= c_smag_reg[k];
                e_smag_reg[k] <= d_smag_reg[k];
            end
            a_neg_reg <= in_neg;
            a_or_reg  <= in_mag[0 +: MW] | in_mag[MW +: MW] | in_mag[2*MW +: MW];
            b_neg_reg <= a_neg_reg;
            b_bl_reg  <= b_bl_next;
            b_deg_reg <= (a_or_reg == '0);
            c_neg_reg <= b_neg_reg;
            c_deg_reg <= b_deg_reg;
            d_neg_reg <= c_neg_reg;
            d_deg_reg <= c_deg_reg;
            e_sum_reg <= SQ_SUM_W'(d_sq_reg[0]) + SQ_SUM_W'(d_sq_reg[1])
                         + SQ_SUM_W'(d_sq_reg[2]);
            e_neg_reg <= d_neg_reg;
            e_deg_reg <= d_deg_reg;
        end
    end

    assign out_valid = e_v_reg;
    assign out_sum   = e_sum_reg;
    assign out_smag  = {e_smag_reg[2], e_smag_reg[1], e_smag_reg[0]};
    assign out_neg   = e_neg_reg;
    assign out_deg   = e_deg_reg;

endmodule

[rtl/tfn_sqrt.sv]
module tfn_sqrt
    import tfn_pkg::*;
#(
    parameter int PLW = 3 * NORM_BITS + 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SQ_SUM_W-1:0] in_sum,
    input  logic [PLW-1:0]      in_pl,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   out_root,
    output logic [PLW-1:0]      out_pl
);

    // one root bit per stage, most significant first
    localparam int TW = SQ_SUM_W + 2;

    logic [SQ_SUM_W-1:0] rem_reg   [ROOT_W];
    logic [SQ_SUM_W-1:0] rem_next  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_next [ROOT_W];
    logic [PLW-1:0]      pl_reg    [ROOT_W];
    logic                v_reg     [ROOT_W];

    // rem holds sum - root^2; setting bit b adds (root << (b+1)) + 4^b
    always_comb begin
        logic [SQ_SUM_W-1:0] rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [TW-1:0]       trial;
        int                  b;
        for (int i = 0; i < ROOT_W; i++) begin
            b       = ROOT_W - 1 - i;
            rem_in  = (i == 0) ? in_sum : rem_reg[(i == 0) ? 0 : i - 1];
            root_in = (i == 0) ? '0 : root_reg[(i == 0) ? 0 : i - 1];
            trial   = (TW'(root_in) << (b + 1)) + (TW'(1) << (2 * b));
            if (trial <= TW'(rem_in)) begin
                rem_next[i]  = rem_in - trial[SQ_SUM_W-1:0];
                root_next[i] = root_in | (ROOT_W'(1) << b);
            end else begin
                rem_next[i]  = rem_in;
                root_next[i] = root_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROOT_W; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < ROOT_W; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            pl_reg[0] <= in_pl;
            for (int i = 1; i < ROOT_W; i++) begin
                pl_reg[i] <= pl_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_pl    = pl_reg[ROOT_W-1];

endmodule

[rtl/tfn_div.sv]
module tfn_div
    import tfn_pkg::*;
#(
    parameter int F = NORMAL_FRAC_BITS_DEF,
    localparam int OW = F + 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [ROOT_W-1:0]      in_len,
    input  logic [3*NORM_BITS-1:0] in_smag,
    input  logic [2:0]             in_neg,
    input  logic                   in_deg,
    output logic                   out_valid,
    output logic [3*OW-1:0]        out_norm,
    output logic                   out_deg
);

    localparam int QW = F + 1;              // quotient never exceeds 2^F
    localparam int NW = NORM_BITS + F + 1;  // numerator m*2^F + len/2
    localparam int RW = ROOT_W + 1;         // partial remainder

    // stage 0 loads the numerator, stages 1..QW each yield one quotient bit
    logic [RW-1:0]     rem_reg  [QW+1][3];
    logic [RW-1:0]     rem_next [QW+1][3];
    logic [QW-1:0]     nlo_reg  [QW+1][3];
    logic [QW-1:0]     nlo_next [QW+1][3];
    logic [QW-1:0]     q_reg    [QW+1][3];
    logic [QW-1:0]     q_next   [QW+1][3];
    logic [ROOT_W-1:0] len_reg  [QW+1];
    logic [2:0]        neg_reg  [QW+1];
    logic              deg_reg  [QW+1];
    logic              v_reg    [QW+1];

    always_comb begin
        logic [NW-1:0] num;
        logic [RW:0]   sh;
        logic [RW:0]   t;
        for (int k = 0; k < 3; k++) begin
            num = {in_smag[k*NORM_BITS +: NORM_BITS], {F{1'b0}}}
                  + NW'(in_len >> 1);
            rem_next[0][k] = RW'(num[NW-1:QW]);
            nlo_next[0][k] = num[QW-1:0];
            q_next[0][k]   = '0;
            for (int j = 1; j <= QW; j++) begin
                sh = {rem_reg[j-1][k], nlo_reg[j-1][k][QW-1]};
                t  = sh - (RW+1)'(len_reg[j-1]);
                nlo_next[j][k] = nlo_reg[j-1][k] << 1;
                if (!t[RW]) begin
                    rem_next[j][k] = t[RW-1:0];
                    q_next[j][k]   = {q_reg[j-1][k][QW-2:0], 1'b1};
                end else begin
                    rem_next[j][k] = sh[RW-1:0];
                    q_next[j][k]   = {q_reg[j-1][k][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= QW; j++) begin
                v_reg[j] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int j = 1; j <= QW; j++) begin
                v_reg[j] <= v_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg    <= rem_next;
            nlo_reg    <= nlo_next;
            q_reg      <= q_next;
            len_reg[0] <= in_len;
            neg_reg[0] <= in_neg;
            deg_reg[0] <= in_deg;
            for (int j = 1; j <= QW; j++) begin
                len_reg[j] <= len_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                deg_reg[j] <= deg_reg[j-1];
            end
        end
    end

    // apply sign; a degenerate triangle gives a zero normal
    always_comb begin
        logic [OW-1:0] qe;
        for (int k = 0; k < 3; k++) begin
            qe = OW'(q_reg[QW][k]);
            if (deg_reg[QW]) begin
                out_norm[k*OW +: OW] = '0;
            end else if (neg_reg[QW][k]) begin
                out_norm[k*OW +: OW] = -qe;
            end else begin
                out_norm[k*OW +: OW] = qe;
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign out_deg   = deg_reg[QW];

endmodule
